FILE: rtl/xcfc_pkg.sv
// shared types, constants and byte classifiers for the xor checksum frame checker
`default_nettype none

package xcfc_pkg;

  // default saturation point of the field counter
  localparam int FIELD_COUNT_MAX_DEFAULT = 63;

  // width of the reported field count and of the min_fields register
  localparam int FC_W = 6;

  localparam logic [FC_W-1:0] MIN_FIELDS_RESET = FC_W'(5);
  localparam logic [FC_W-1:0] FC_OUT_MAX       = FC_W'(63);

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CONTENT,
    PH_CHECK
  } frame_phase_t;

  typedef enum logic [1:0] {
    HX_SKIP,
    HX_DIGITS,
    HX_DONE
  } hex_phase_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FRAME = 2'd1,
    STATUS_MISMATCH = 2'd2,
    STATUS_FEW      = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } rx_item_t;

  typedef struct packed {
    status_t         status;
    logic [FC_W-1:0] field_count;
    logic [7:0]      computed_sum;
    logic [7:0]      received_sum;
  } result_t;

  // space, tab, lf, vt, ff, cr
  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else begin
      v = b - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/xcfc_in_reg.sv
// input register stage holding one received byte request
`default_nettype none

module xcfc_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_valid,
  output logic                   rx_stall,
  input  wire xcfc_pkg::rx_item_t rx,
  input  wire logic              advance_ok,
  output logic                   item_valid,
  output xcfc_pkg::rx_item_t     item,
  output logic                   consume
);
  import xcfc_pkg::*;

  logic accept;
  logic item_valid_next;

  assign consume  = item_valid && advance_ok;
  assign rx_stall = item_valid && !advance_ok;
  assign accept   = rx_valid && !rx_stall;

  always_comb begin
    item_valid_next = item_valid;
    if (accept) begin
      item_valid_next = 1'b1;
    end else if (consume) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= rx;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/xcfc_tracker.sv
// frame phase tracking, content xor, comma count, hex checksum and verdict
`default_nettype none

module xcfc_tracker #(
  parameter int FIELD_COUNT_MAX = xcfc_pkg::FIELD_COUNT_MAX_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire xcfc_pkg::rx_item_t        item,
  input  wire logic [xcfc_pkg::FC_W-1:0] min_fields,
  output xcfc_pkg::result_t              result
);
  import xcfc_pkg::*;

  localparam int CNT_W = $clog2(FIELD_COUNT_MAX + 1);
  localparam int CMP_W = (CNT_W > FC_W) ? CNT_W : FC_W;
  // commas counted up to the point where fields reach the maximum
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(FIELD_COUNT_MAX - 1);

  frame_phase_t     phase, phase_next;
  hex_phase_t       hxp, hxp_next;
  logic [7:0]       xor_acc, xor_next;
  logic [7:0]       hex_acc, hex_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             early, early_next;

  logic [CNT_W-1:0] fields;
  logic [CMP_W-1:0] fields_w;
  logic [7:0]       b;

  assign b = item.rx_byte;

  // next state for the current byte
  always_comb begin
    phase_next = phase;
    hxp_next   = hxp;
    xor_next   = xor_acc;
    hex_next   = hex_acc;
    cnt_next   = cnt;
    early_next = early;
    case (phase)
      PH_HUNT: begin
        if (!early) begin
          if (b == CHAR_DOLLAR) begin
            phase_next = PH_CONTENT;
          end else if (b == CHAR_STAR) begin
            early_next = 1'b1;
          end
        end
      end
      PH_CONTENT: begin
        if (b == CHAR_STAR) begin
          phase_next = PH_CHECK;
        end else begin
          xor_next = xor_acc ^ b;
          if (b == CHAR_COMMA && cnt != CNT_SAT) begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      PH_CHECK: begin
        case (hxp)
          HX_SKIP: begin
            if (is_hex(b)) begin
              hex_next = {4'h0, hex_nibble(b)};
              hxp_next = HX_DIGITS;
            end else if (!is_space(b)) begin
              hxp_next = HX_DONE;
            end
          end
          HX_DIGITS: begin
            if (is_hex(b)) begin
              hex_next = {hex_acc[3:0], hex_nibble(b)};
            end else begin
              hxp_next = HX_DONE;
            end
          end
          default: hxp_next = hxp;
        endcase
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // verdict from the state after this byte
  always_comb begin
    fields   = cnt_next + CNT_W'(1);
    fields_w = CMP_W'(fields);
    result   = '0;
    if (phase_next != PH_CHECK) begin
      result.status = STATUS_NO_FRAME;
    end else begin
      if (xor_next != hex_next) begin
        result.status = STATUS_MISMATCH;
      end else if (fields_w < CMP_W'(min_fields)) begin
        result.status = STATUS_FEW;
      end else begin
        result.status = STATUS_OK;
      end
      result.field_count  = (fields_w > CMP_W'(FC_OUT_MAX)) ? FC_OUT_MAX
                                                            : fields_w[FC_W-1:0];
      result.computed_sum = xor_next;
      result.received_sum = hex_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_packet)) begin
      phase   <= PH_HUNT;
      hxp     <= HX_SKIP;
      xor_acc <= '0;
      hex_acc <= '0;
      cnt     <= '0;
      early   <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      hxp     <= hxp_next;
      xor_acc <= xor_next;
      hex_acc <= hex_next;
      cnt     <= cnt_next;
      early   <= early_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/xcfc_out_reg.sv
// result register toward the downstream consumer
`default_nettype none

module xcfc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire xcfc_pkg::result_t load_data,
  output logic                   free,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output xcfc_pkg::result_t      res
);
  import xcfc_pkg::*;

  logic res_valid_next;

  assign free = !res_valid || !res_stall;

  always_comb begin
    res_valid_next = res_valid;
    if (load) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/xor_checksum_frame_checker.sv
// top level of the xor checksum frame checker
//
//   channel  signals                         request
//   rx       rx_valid rx_stall rx            one packet byte plus end mark
//   res      res_valid res_stall res         one verdict per packet
//   cfg      cfg_valid cfg_ready cfg_data    min_fields write
//
// one byte request is taken every cycle unless an end-marked byte waits
// for room in the result register; a byte goes input register -> tracker
// logic -> result register, so res_valid rises once the end-marked byte
// leaves the input register. a stalled result holds back an end-marked
// byte and those behind it; other bytes keep flowing. synchronous reset
// clears the frame state, the valid flags and sets min_fields to 5.
`default_nettype none

module xor_checksum_frame_checker #(
  parameter int FIELD_COUNT_MAX = xcfc_pkg::FIELD_COUNT_MAX_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rx_valid,
  output logic                           rx_stall,
  input  wire xcfc_pkg::rx_item_t        rx,
  output logic                           res_valid,
  input  wire logic                      res_stall,
  output xcfc_pkg::result_t              res,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [xcfc_pkg::FC_W-1:0] cfg_data
);
  import xcfc_pkg::*;

  logic            item_valid;
  rx_item_t        item;
  logic            consume;
  logic            advance_ok;
  logic            out_free;
  result_t         verdict;
  logic [FC_W-1:0] min_fields;

  // user must write config only while idle; not enforced, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_fields <= MIN_FIELDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_fields <= cfg_data;
    end
  end

  // only an end-marked byte needs room in the result register
  assign advance_ok = !item.end_of_packet || out_free;

  xcfc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx         (rx),
    .advance_ok (advance_ok),
    .item_valid (item_valid),
    .item       (item),
    .consume    (consume)
  );

  xcfc_tracker #(
    .FIELD_COUNT_MAX (FIELD_COUNT_MAX)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (consume),
    .item       (item),
    .min_fields (min_fields),
    .result     (verdict)
  );

  // verdict is loaded on the end-marked byte
  xcfc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (consume && item_valid && item.end_of_packet),
    .load_data (verdict),
    .free      (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: tb/tb_xor_checksum_frame_checker.sv
// self-checking testbench for the xor checksum frame checker
`timescale 1ns / 1ps

module tb_xor_checksum_frame_checker;
  import xcfc_pkg::*;

  // predictor limit matches the default parameter of the block
  localparam int FIELD_LIMIT = FIELD_COUNT_MAX_DEFAULT;
  // slack after the last verdict while draining
  localparam int SETTLE_CYCLES = 6;
  // cycles with no accepted request before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 260;
  localparam int PHASES = 6;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_X       = 8'h78;
  localparam logic [7:0] ASCII_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_t;

  // one row of the directed table: a byte request, optionally with a typed verdict
  typedef struct packed {
    rx_item_t item;
    logic     pinned;
    result_t  verdict;
  } stim_row_t;

  logic           clk = 1'b0;
  logic           rst;
  logic           rx_valid;
  logic           rx_stall;
  rx_item_t       rx_item;
  logic           res_valid;
  logic           res_stall;
  result_t        res_word;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [FC_W-1:0] cfg_data;

  always #10 clk = ~clk;

  xor_checksum_frame_checker uut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx        (rx_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // frame tracker shadow: mirrors what the block should remember per packet
  // ---------------------------------------------------------------------------
  frame_phase_t    trk_phase;
  hex_phase_t      hex_state;
  logic [7:0]      sum_xor;
  logic [7:0]      sum_hex;
  int              commas;
  logic            star_first;
  logic [FC_W-1:0] min_fields_shadow;

  result_t   verdicts_due[$];
  stim_row_t directed_rows[$];
  logic [7:0] frame_q[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        burst_left = 0;

  function automatic void clear_tracker();
    trk_phase  = PH_HUNT;
    hex_state  = HX_SKIP;
    sum_xor    = '0;
    sum_hex    = '0;
    commas     = 0;
    star_first = 1'b0;
  endfunction

  // advance the shadow by one byte; returns 1 when the byte closes a packet
  function automatic bit track_byte(input rx_item_t item, output result_t verdict);
    logic [7:0] b;
    logic [4:0] nib;   // bit 4 flags a hex digit
    int         fields;
    b = item.rx_byte;
    if (b >= 8'h30 && b <= 8'h39) begin
      nib = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      nib = {1'b1, b[3:0] + 4'd9};
    end else begin
      nib = 5'd0;
    end

    case (trk_phase)
      PH_HUNT: begin
        // a star ahead of the dollar poisons the rest of the packet
        if (!star_first) begin
          if (b == CHAR_DOLLAR) trk_phase = PH_CONTENT;
          else if (b == CHAR_STAR) star_first = 1'b1;
        end
      end
      PH_CONTENT: begin
        if (b == CHAR_STAR) begin
          trk_phase = PH_CHECK;
        end else begin
          sum_xor = sum_xor ^ b;
          if (b == CHAR_COMMA && commas < FIELD_LIMIT) commas++;
        end
      end
      default: begin
        case (hex_state)
          HX_SKIP: begin
            if (nib[4]) begin
              sum_hex   = {4'd0, nib[3:0]};
              hex_state = HX_DIGITS;
            end else if (!(b == ASCII_SPACE || (b >= 8'h09 && b <= 8'h0D))) begin
              hex_state = HX_DONE;
            end
          end
          HX_DIGITS: begin
            if (nib[4]) sum_hex = {sum_hex[3:0], nib[3:0]};
            else hex_state = HX_DONE;
          end
          default: ;
        endcase
      end
    endcase

    verdict = '0;
    if (!item.end_of_packet) return 1'b0;

    if (trk_phase == PH_CHECK) begin
      fields = commas + 1;
      if (fields > FIELD_LIMIT) fields = FIELD_LIMIT;
      if (fields > 63) fields = 63;
      verdict.field_count  = fields[FC_W-1:0];
      verdict.computed_sum = sum_xor;
      verdict.received_sum = sum_hex;
      // mismatch takes priority over a short field count
      if (sum_xor != sum_hex) verdict.status = STATUS_MISMATCH;
      else if (fields < min_fields_shadow) verdict.status = STATUS_FEW;
      else verdict.status = STATUS_OK;
    end else begin
      verdict.status = STATUS_NO_FRAME;
    end
    clear_tracker();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------
  function automatic void note_byte(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.item.rx_byte = b;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void note_end(input logic [7:0] b, input status_t st,
                                   input logic [FC_W-1:0] fc, input logic [7:0] cs,
                                   input logic [7:0] rs);
    stim_row_t row;
    row = '0;
    row.item.rx_byte       = b;
    row.item.end_of_packet = 1'b1;
    row.pinned             = 1'b1;
    row.verdict.status       = st;
    row.verdict.field_count  = fc;
    row.verdict.computed_sum = cs;
    row.verdict.received_sum = rs;
    directed_rows = {directed_rows, row};
  endfunction

  // ---------------------------------------------------------------------------
  // random packet builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ASCII_ZERO + 8'(n);
    return ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(n - 4'd10);
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    frame_q = {frame_q, v};
  endfunction

  // mostly well formed packets with random content, some cut short, some noise
  function automatic void compose_frame();
    logic [7:0] sum;
    logic [7:0] v;
    int         kind;
    int         n;
    int         r;
    int         style;
    bit         wide;
    frame_q.delete();
    kind = $urandom_range(0, 99);

    if (kind >= 85) begin
      // noise biased toward the marker bytes
      n = $urandom_range(1, 12);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: add_byte(CHAR_DOLLAR);
          1: add_byte(CHAR_STAR);
          2: add_byte(CHAR_COMMA);
          default: add_byte(8'($urandom));
        endcase
      end
      return;
    end

    // leading junk that is skipped while hunting
    repeat ($urandom_range(0, 2)) begin
      do v = 8'($urandom); while (v == CHAR_DOLLAR || v == CHAR_STAR);
      add_byte(v);
    end
    add_byte(CHAR_DOLLAR);

    // now and then a comma-heavy body to push the field count into saturation
    wide = ($urandom_range(0, 19) == 0);
    n = wide ? $urandom_range(62, 70) : $urandom_range(0, 16);
    sum = '0;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 3 || (wide && r != 9)) v = CHAR_COMMA;
      else if (r == 3) v = CHAR_DOLLAR;
      else do v = 8'($urandom); while (v == CHAR_STAR);
      sum = sum ^ v;
      add_byte(v);
    end
    add_byte(CHAR_STAR);

    // leading whitespace before the digits
    repeat ($urandom_range(0, 2))
      add_byte(($urandom_range(0, 5) == 0) ? ASCII_SPACE : 8'($urandom_range(9, 13)));

    style = $urandom_range(0, 9);
    if (style == 8) begin
      // hex prefix stops the digits after the leading zero
      add_byte(ASCII_ZERO);
      add_byte(ASCII_X);
    end
    if (style == 9) begin
      repeat ($urandom_range(1, 4)) add_byte(hex_char(4'($urandom)));
    end else if (style != 7) begin
      v = (style == 6) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
      add_byte(hex_char(v[7:4]));
      add_byte(hex_char(v[3:0]));
    end

    // trailing random bytes; hex digits among them extend the received checksum
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom));

    // broken packets: end mark lands somewhere in the middle
    if (kind >= 70) begin
      n = $urandom_range(1, frame_q.size());
      while (frame_q.size() > n) void'(frame_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request drivers; called at a falling edge, return at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_item(input rx_item_t item, input logic pinned, input result_t pin);
    int      gap;
    result_t predicted;
    if (burst_left == 0) begin
      // bursty sender: random gap, sometimes none, then a fresh burst length
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        rx_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    rx_valid = 1'b1;
    rx_item  = item;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    // request taken at this edge
    items_sent++;
    if (track_byte(item, predicted)) verdicts_due = {verdicts_due, (pinned ? pin : predicted)};
    @(negedge clk);
  endtask

  task automatic write_min_fields(input logic [FC_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_fields_shadow = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every verdict, then let the pipeline go quiet
  task automatic drain();
    rx_valid = 1'b0;
    burst_left = 0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  initial begin : result_stall_pattern
    stall_mode_t mode;
    int          seg;
    res_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(8, 40);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  res_stall = 1'b0;
          STALL_LIGHT: res_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: res_stall = ($urandom_range(0, 3) != 0);
          default:     res_stall = 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin : verdict_check
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict status %0d fields %0d sums %02h/%02h", $time,
                 res_word.status, res_word.field_count, res_word.computed_sum,
                 res_word.received_sum);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (res_word.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   res_word.status);
          mismatches++;
        end
        if (res_word.field_count != want.field_count) begin
          $display("%0t: field_count expected %0d actual %0d", $time, want.field_count,
                   res_word.field_count);
          mismatches++;
        end
        if (res_word.computed_sum != want.computed_sum) begin
          $display("%0t: computed_sum expected %02h actual %02h", $time,
                   want.computed_sum, res_word.computed_sum);
          mismatches++;
        end
        if (res_word.received_sum != want.received_sum) begin
          $display("%0t: received_sum expected %02h actual %02h", $time,
                   want.received_sum, res_word.received_sum);
          mismatches++;
        end
      end
    end
  end

  // hang detector: counts cycles in which no request of any kind is taken
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx_valid && !rx_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rx_item_t        item;
    int              target;
    logic [FC_W-1:0] setting;

    rst       = 1'b1;
    rx_valid  = 1'b0;
    rx_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    min_fields_shadow = MIN_FIELDS_RESET;
    clear_tracker();

    // star before dollar rejects the packet
    note_byte(CHAR_STAR);
    note_byte(CHAR_DOLLAR);
    note_end(8'h41, STATUS_NO_FRAME, '0, 8'h00, 8'h00);
    // dollar without a star, extreme byte values
    note_byte(8'h00);
    note_byte(CHAR_DOLLAR);
    note_end(8'hFF, STATUS_NO_FRAME, '0, 8'h00, 8'h00);
    // mismatch wins over too few fields; space skipped, hex prefix stops digits
    note_byte(CHAR_DOLLAR);
    note_byte(CHAR_COMMA);
    note_byte(CHAR_STAR);
    note_byte(ASCII_SPACE);
    note_byte(ASCII_ZERO);
    note_byte(ASCII_X);
    note_end(8'h31, STATUS_MISMATCH, 6'd2, 8'h2C, 8'h00);
    // empty body and empty checksum, one field under the reset minimum of five
    note_byte(CHAR_DOLLAR);
    note_end(CHAR_STAR, STATUS_FEW, 6'd1, 8'h00, 8'h00);
    // second dollar is content; five fields meet the reset minimum
    note_byte(CHAR_DOLLAR);
    note_byte(CHAR_DOLLAR);
    repeat (4) note_byte(CHAR_COMMA);
    note_byte(CHAR_STAR);
    note_byte(8'h32);
    note_end(8'h34, STATUS_OK, 6'd5, 8'h24, 8'h24);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table runs with the reset minimum
    for (int i = 0; i < directed_rows.size(); i++)
      send_item(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].verdict);

    // random phases, each under its own minimum field setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: setting = '0;
        1: setting = FC_OUT_MAX;
        2: setting = 6'd1;
        3: setting = FC_W'($urandom_range(0, 63));
        4: setting = 6'd3;
        default: setting = MIN_FIELDS_RESET;
      endcase
      write_min_fields(setting);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        compose_frame();
        foreach (frame_q[i]) begin
          item.rx_byte       = frame_q[i];
          item.end_of_packet = (i == frame_q.size() - 1);
          send_item(item, 1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
